[sv/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam int KEY_W          = 32;
  localparam int VAL_W          = 31;
  localparam int CFG_W          = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] store_value;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic sweep_start;
    logic decide;
    logic rank_mode;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic need_rank;
    logic out_free;
  } sts_t;

endpackage

[sv/lfu_ram.sv]
// ----------------------------------------------------------------------------
// lfu_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: lookup sweep, decision, rank sweep, result hand-off.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lfu_pkg::sts_t sts,
  output lfu_pkg::cmd_t cmd
);
  import lfu_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_RANK   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.rank_mode   = (state_r == ST_RANK);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load        = 1'b1;
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.sweep_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.need_rank) begin
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_RANK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RANK: begin
        if (sts.sweep_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

[sv/lfu_dpath.sv]
// ----------------------------------------------------------------------------
// lfu_dpath
// Entry storage, sweep engine, victim search, rank update and result register.
// ----------------------------------------------------------------------------
module lfu_dpath #(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lfu_pkg::in_t               in_data,
  input  logic                       cfg_we,
  input  logic [lfu_pkg::CFG_W-1:0]  cfg_wdata,
  input  lfu_pkg::cmd_t              cmd,
  output lfu_pkg::sts_t              sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lfu_pkg::out_t              out_data
);
  import lfu_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // configuration and control state
  logic [CFG_W-1:0]  cfg_r;
  logic [CAPACITY-1:0] valid_r;
  logic [CW-1:0]     count_r;
  logic              out_valid_r;
  out_t              out_r;
  out_t              res_r;
  in_t               item_r;

  // sweep engine
  logic            issue_r, pipe_vld_r;
  logic [IW-1:0]   idx_r, pipe_idx_r;

  // scan trackers
  logic                  hit_found_r, free_found_r, vic_found_r;
  logic [IW-1:0]         hit_idx_r, free_idx_r, vic_idx_r;
  logic [VAL_W-1:0]      hit_val_r;
  logic [COUNT_BITS-1:0] hit_cnt_r, vic_cnt_r;
  logic [IW-1:0]         hit_rank_r, vic_rank_r;
  logic [KEY_W-1:0]      vic_key_r;

  // rank sweep plan
  logic          rk_touch_r, rk_evict_r;
  logic [IW-1:0] rk_ref_r, tgt_r;

  // ram ports
  logic [KEY_W-1:0]      key_rd;
  logic [VAL_W-1:0]      val_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [IW-1:0]         rank_rd;
  logic                  key_we, val_we, cnt_we, rank_we;
  logic [IW-1:0]         wr_addr;
  logic [VAL_W-1:0]      val_wd;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [IW-1:0]         rank_wd;

  lfu_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(key_we), .waddr(wr_addr), .wdata(item_r.lookup_key),
    .raddr(idx_r), .rdata(key_rd));
  lfu_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(val_we), .waddr(wr_addr), .wdata(val_wd),
    .raddr(idx_r), .rdata(val_rd));
  lfu_ram #(.WIDTH(COUNT_BITS), .DEPTH(CAPACITY)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(wr_addr), .wdata(cnt_wd),
    .raddr(idx_r), .rdata(cnt_rd));
  lfu_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_rank (
    .clk(clk), .we(rank_we), .waddr(pipe_idx_r), .wdata(rank_wd),
    .raddr(idx_r), .rdata(rank_rd));

  // decision logic
  logic        is_put, cap_zero, full, do_insert, do_touch, do_evict;
  logic [31:0] cap_eff;
  logic [IW-1:0] ins_idx;
  logic        cell_valid;

  always_comb begin
    is_put    = (item_r.func == FUNC_PUT);
    cap_zero  = (cfg_r == '0);
    cap_eff   = (32'(cfg_r) > CAPACITY) ? CAPACITY : 32'(cfg_r);
    full      = (32'(count_r) >= cap_eff);
    do_touch  = hit_found_r && (!is_put || !cap_zero);
    do_insert = is_put && !hit_found_r && !cap_zero;
    do_evict  = do_insert && full;
    // first free slot after the victim is dropped
    if (do_evict && !(free_found_r && (free_idx_r < vic_idx_r))) begin
      ins_idx = vic_idx_r;
    end else begin
      ins_idx = free_idx_r;
    end
  end

  // single writes at the decide step
  always_comb begin
    key_we  = cmd.decide && do_insert;
    val_we  = cmd.decide && ((do_touch && is_put) || do_insert);
    cnt_we  = cmd.decide && (do_touch || do_insert);
    wr_addr = do_insert ? ins_idx : hit_idx_r;
    val_wd  = item_r.store_value;
    if (do_insert) begin
      cnt_wd = COUNT_BITS'(1);
    end else if (hit_cnt_r == CNT_MAX) begin
      cnt_wd = hit_cnt_r;
    end else begin
      cnt_wd = hit_cnt_r + 1'b1;
    end
  end

  // rank rewrite during the rank sweep
  always_comb begin
    rank_we = pipe_vld_r && cmd.rank_mode;
    if (pipe_idx_r == tgt_r) begin
      rank_wd = '0;
    end else if (rk_touch_r) begin
      rank_wd = (rank_rd < rk_ref_r) ? rank_rd + 1'b1 : rank_rd;
    end else if (rk_evict_r) begin
      rank_wd = (rank_rd > rk_ref_r) ? rank_rd : rank_rd + 1'b1;
    end else begin
      rank_wd = rank_rd + 1'b1;
    end
  end

  assign cell_valid = valid_r[pipe_idx_r];

  // sweep engine: one entry issued per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r    <= 1'b0;
      pipe_vld_r <= 1'b0;
    end else begin
      pipe_vld_r <= issue_r;
      if (cmd.sweep_start) begin
        issue_r <= 1'b1;
      end else if (issue_r && (idx_r == LAST_IDX)) begin
        issue_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx_r <= idx_r;
    if (cmd.sweep_start) begin
      idx_r <= '0;
    end else if (issue_r && (idx_r != LAST_IDX)) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // lookup, free slot and victim trackers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r       <= in_data;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      vic_found_r  <= 1'b0;
    end else if (pipe_vld_r && !cmd.rank_mode) begin
      if (cell_valid && !hit_found_r && (key_rd == item_r.lookup_key)) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= pipe_idx_r;
        hit_val_r   <= val_rd;
        hit_cnt_r   <= cnt_rd;
        hit_rank_r  <= rank_rd;
      end
      if (!cell_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= pipe_idx_r;
      end
      if (cell_valid && (!vic_found_r || (cnt_rd < vic_cnt_r) ||
          ((cnt_rd == vic_cnt_r) && (rank_rd > vic_rank_r)))) begin
        vic_found_r <= 1'b1;
        vic_idx_r   <= pipe_idx_r;
        vic_cnt_r   <= cnt_rd;
        vic_rank_r  <= rank_rd;
        vic_key_r   <= key_rd;
      end
    end
  end

  // rank plan and result captured at decide
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      rk_touch_r            <= do_touch;
      rk_evict_r            <= do_evict;
      rk_ref_r              <= do_touch ? hit_rank_r : vic_rank_r;
      tgt_r                 <= do_insert ? ins_idx : hit_idx_r;
      res_r.hit             <= hit_found_r;
      res_r.read_value      <= (!is_put && hit_found_r) ? hit_val_r : '0;
      res_r.evicted         <= do_evict;
      res_r.evicted_key     <= do_evict ? vic_key_r : '0;
    end
  end

  // valid bits, fill count and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      cfg_r   <= CFG_RESET;
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      if (cmd.decide && do_insert) begin
        if (do_evict) begin
          valid_r[vic_idx_r] <= 1'b0;
        end else begin
          count_r <= count_r + 1'b1;
        end
        valid_r[ins_idx] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_r <= res_r;
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign sts.sweep_done = !issue_r && !pipe_vld_r;
  assign sts.need_rank  = do_touch || do_insert;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

[sv/lfu_cache_lru_tiebreak_top.sv]
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_top
// Fully associative key-value cache, LFU replacement with LRU tie-break.
// ----------------------------------------------------------------------------
//  channel  | ports                         | transfer
//  ---------+-------------------------------+-----------------------------
//  input    | in_valid, in_ready, in_data   | get or put transaction
//  result   | out_valid, out_ready, out_data| one result per transaction
//  config   | cfg_we, cfg_wdata             | capacity, write only
//
//  One transaction at a time, sequenced over the entry RAMs one entry per
//  cycle: a lookup sweep, a decide step, then a rank sweep for an insert or
//  for a hit other than a put at zero capacity, then the result hand-off.
//  Reset is synchronous; no clearing pass, valid bits clear. A waiting
//  result holds the block in its last step until taken.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_top #(
  parameter int CAPACITY   = lfu_pkg::DEF_CAPACITY,
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lfu_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lfu_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_wdata
);
  import lfu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfu_dpath #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the LFU cache with LRU tie-break: random get/put traffic over
// small key pools, a software model of the store predicting every result, and
// capacity changes between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import lfu_pkg::*;

  localparam int NSLOT   = DEF_CAPACITY;
  localparam int CNT_MAX = (1 << DEF_COUNT_BITS) - 1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  // model state
  bit                  mdl_valid [NSLOT];
  logic [KEY_W-1:0]    mdl_key   [NSLOT];
  logic [VAL_W-1:0]    mdl_value [NSLOT];
  int unsigned         mdl_uses  [NSLOT];
  int unsigned         mdl_rank  [NSLOT];
  int unsigned         mdl_fill;
  int unsigned         mdl_cap;

  in_t                 pending_txn[$];
  out_t                expected_res[$];
  int                  fail_cnt = 0;
  int                  hold_off = 0;
  int                  drv_gap = 0;
  bit                  stall_req = 1'b0;

  lfu_cache_lru_tiebreak_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // move entry e to most recent and bump its count
  function automatic void promote(int e);
    for (int i = 0; i < NSLOT; i++)
      if (mdl_valid[i] && mdl_rank[i] < mdl_rank[e]) mdl_rank[i]++;
    mdl_rank[e] = 0;
    if (mdl_uses[e] < CNT_MAX) mdl_uses[e]++;
  endfunction

  // compute the result of one transaction and update the model
  function automatic out_t cache_access(in_t t);
    out_t r;
    int   e;
    int   v;
    int unsigned cap;
    r = '0;
    e = -1;
    v = -1;
    cap = (mdl_cap > NSLOT) ? NSLOT : mdl_cap;
    for (int i = 0; i < NSLOT; i++)
      if (e < 0 && mdl_valid[i] && mdl_key[i] == t.lookup_key) e = i;
    r.hit = (e >= 0);
    if (t.func == FUNC_GET) begin
      if (e >= 0) begin
        r.read_value = mdl_value[e];
        promote(e);
      end
      return r;
    end
    if (cap == 0) return r;
    if (e >= 0) begin
      mdl_value[e] = t.store_value;
      promote(e);
      return r;
    end
    // evict least used, oldest among equals
    if (mdl_fill >= cap) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (!mdl_valid[i]) continue;
        if (v < 0 || mdl_uses[i] < mdl_uses[v] ||
            (mdl_uses[i] == mdl_uses[v] && mdl_rank[i] > mdl_rank[v])) v = i;
      end
      if (v >= 0) begin
        r.evicted = 1'b1;
        r.evicted_key = mdl_key[v];
        mdl_valid[v] = 1'b0;
        for (int i = 0; i < NSLOT; i++)
          if (mdl_valid[i] && mdl_rank[i] > mdl_rank[v]) mdl_rank[i]--;
        if (mdl_fill > 0) mdl_fill--;
      end
    end
    e = -1;
    for (int i = 0; i < NSLOT; i++)
      if (e < 0 && !mdl_valid[i]) e = i;
    if (e < 0) return r;
    for (int i = 0; i < NSLOT; i++)
      if (mdl_valid[i]) mdl_rank[i]++;
    mdl_valid[e] = 1'b1;
    mdl_key[e]   = t.lookup_key;
    mdl_value[e] = t.store_value;
    mdl_uses[e]  = 1;
    mdl_rank[e]  = 0;
    mdl_fill++;
    return r;
  endfunction

  function automatic in_t make_txn(bit put, logic [KEY_W-1:0] k, logic [VAL_W-1:0] d);
    in_t t;
    t.func = put ? FUNC_PUT : FUNC_GET;
    t.lookup_key = k;
    t.store_value = d;
    return t;
  endfunction

  // key from a small pool so hits and evictions are common
  function automatic logic [KEY_W-1:0] pick_key(int pool);
    if ($urandom_range(0, 19) == 0) return $urandom;
    return 32'hA5C3_0000 ^ $urandom_range(0, pool - 1);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold
    end else begin
      if (in_valid) begin
        expected_res.push_back(cache_access(in_data));
        drv_gap = gap_len();
      end
      if (drv_gap > 0) begin
        drv_gap--;
        in_valid <= 1'b0;
      end else if (pending_txn.size() > 0) begin
        in_data  <= pending_txn.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor with random receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_cnt++;
        end else begin
          out_t x;
          x = expected_res.pop_front();
          if (x.hit !== out_data.hit)
            $display("%0t: hit exp %0d got %0d", $time, x.hit, out_data.hit);
          if (x.read_value !== out_data.read_value)
            $display("%0t: read_value exp %h got %h", $time, x.read_value,
                     out_data.read_value);
          if (x.evicted !== out_data.evicted)
            $display("%0t: evicted exp %0d got %0d", $time, x.evicted,
                     out_data.evicted);
          if (x.evicted_key !== out_data.evicted_key)
            $display("%0t: evicted_key exp %h got %h", $time, x.evicted_key,
                     out_data.evicted_key);
          if (x !== out_data) fail_cnt++;
        end
      end
      if (stall_req) begin
        stall_req = 1'b0;
        hold_off = 400;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0) ||
                     ($urandom_range(0, 9) == 0 && 1'b1);
        if ($urandom_range(0, 19) == 0) hold_off = gap_len();
      end
    end
  end

  task automatic drain();
    while (pending_txn.size() > 0 || in_valid || expected_res.size() > 0)
      @(posedge clk);
    // let an unfinished transaction settle
    repeat (2 * NSLOT + 10) @(posedge clk);
  endtask

  task automatic set_capacity(int unsigned c);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    mdl_cap = c;
  endtask

  task automatic random_phase(int n, int pool);
    for (int i = 0; i < n; i++)
      pending_txn.push_back(make_txn($urandom_range(0, 99) < 55, pick_key(pool),
                                     VAL_W'($urandom)));
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_key[i] = '0;
      mdl_value[i] = '0;
      mdl_uses[i] = 0;
      mdl_rank[i] = 0;
    end
    mdl_fill = 0;
    mdl_cap = 32'(CFG_RESET);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, both operations, get miss, then evictions at capacity two
    pending_txn.push_back(make_txn(1'b0, 32'h0, '0));
    pending_txn.push_back(make_txn(1'b1, 32'h0, '0));
    pending_txn.push_back(make_txn(1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    pending_txn.push_back(make_txn(1'b0, 32'hFFFF_FFFF, '0));
    pending_txn.push_back(make_txn(1'b0, 32'h0, 31'h7FFF_FFFF));
    pending_txn.push_back(make_txn(1'b1, 32'h0, 31'h1234_5678));
    drain();
    set_capacity(2);
    pending_txn.push_back(make_txn(1'b1, 32'h11, 31'h1));
    pending_txn.push_back(make_txn(1'b1, 32'h22, 31'h2));
    pending_txn.push_back(make_txn(1'b0, 32'h22, '0));
    pending_txn.push_back(make_txn(1'b1, 32'h33, 31'h3));
    pending_txn.push_back(make_txn(1'b1, 32'h44, 31'h4));
    drain();
    // zero capacity: puts ignored, gets still work
    set_capacity(0);
    pending_txn.push_back(make_txn(1'b1, 32'h55, 31'h5));
    pending_txn.push_back(make_txn(1'b1, 32'h44, 31'h6));
    pending_txn.push_back(make_txn(1'b0, 32'h44, '0));
    pending_txn.push_back(make_txn(1'b0, 32'h55, '0));
    drain();
    // above the entry count limit clamps to the full size
    set_capacity(31);
    random_phase(120, 24);
    // long receiver stall while traffic keeps coming
    stall_req = 1'b1;
    drain();
    // lowered capacity below the fill level
    set_capacity(3);
    random_phase(100, 8);
    drain();
    set_capacity(16);
    random_phase(120, 20);
    drain();
    set_capacity(1);
    random_phase(60, 4);
    drain();
    set_capacity(9);
    random_phase(100, 14);
    drain();
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
